@@ design/thermistor_temperature_converter_assert.svh @@
// Assertion macros shared by the converter RTL.
// Each macro expects clk and rst_n in scope.
`ifndef THERMISTOR_TEMPERATURE_CONVERTER_ASSERT_SVH
`define THERMISTOR_TEMPERATURE_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ttc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared constants, codes and types of the thermistor converter.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int SAMPLES_PER_RESULT_DEF = 16;

  localparam int ADC_W    = 10;
  localparam int SERIES_W = 24;
  localparam int COEF_W   = 48;
  localparam int TEMP_W   = 16;
  localparam int RES_W    = 24;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADC_W-1:0] ADC_FULL = 10'd1023;

  // sample status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OPEN  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A0     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A3     = 2'd3;

  localparam logic [SERIES_W-1:0] SERIES_RST = 24'd10000;
  localparam logic [COEF_W-1:0]   A0_RST     = 48'd72724000000000;
  localparam logic [COEF_W-1:0]   A1_RST     = 48'd17138000000000;
  localparam logic [COEF_W-1:0]   A3_RST     = 48'd14550000000;

  // arithmetic
  localparam int MUL_W   = 48;   // operand magnitude width
  localparam int PROD_W  = 96;
  localparam int CHUNK_W = 16;   // multiplier bits per cycle
  localparam int DIV_W   = 64;

  localparam logic [MUL_W-1:0] LN2_Q30    = 48'd744261118;
  localparam logic [41:0]      OFFSET_K128 = 42'd34962;  // 34963 - 1 (round half up)

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ design/ttc_mul.sv @@
// ----------------------------------------------------------------------------
// ttc_mul
// Unsigned 48x48 multiplier, 16 multiplier bits per cycle.
// ----------------------------------------------------------------------------
module ttc_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [ttc_pkg::MUL_W-1:0]  a_i,
  input  logic [ttc_pkg::MUL_W-1:0]  b_i,
  output ttc_pkg::unit_sts_t         sts_o,
  output logic [ttc_pkg::PROD_W-1:0] prod_o
);
  import ttc_pkg::*;

  localparam int STEPS = MUL_W / CHUNK_W;
  localparam int CNT_W = $clog2(STEPS);

  logic [MUL_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [MUL_W+CHUNK_W-1:0] pp;

  assign pp = a_r * b_r[MUL_W-1 -: CHUNK_W];

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      a_nxt    = a_i;
      b_nxt    = b_i;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r << CHUNK_W) + PROD_W'(pp);
      b_nxt   = b_r << CHUNK_W;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign prod_o     = acc_r;

endmodule

@@ design/ttc_div.sv @@
// ----------------------------------------------------------------------------
// ttc_div
// Unsigned 64/64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [ttc_pkg::DIV_W-1:0] num_i,
  input  logic [ttc_pkg::DIV_W-1:0] den_i,
  output ttc_pkg::unit_sts_t        sts_o,
  output logic [ttc_pkg::DIV_W-1:0] quo_o
);
  import ttc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] num_r, num_nxt, den_r, den_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0]   trial, diff;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      num_nxt  = num_i;
      den_nxt  = den_i;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
        num_nxt = {num_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        num_nxt = {num_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;
  assign quo_o      = num_r;

endmodule

@@ design/ttc_front.sv @@
// ----------------------------------------------------------------------------
// ttc_front
// Classifies samples and sums each group; hands finished groups on.
// ----------------------------------------------------------------------------
module ttc_front #(
  parameter int SAMPLES_PER_RESULT = ttc_pkg::SAMPLES_PER_RESULT_DEF,
  parameter int SUM_W = $clog2(SAMPLES_PER_RESULT * 1023 + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,    // [9:0] adc_sample
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output logic [SUM_W+ttc_pkg::STAT_W-1:0] push_data_o  // {sum, status}
);
  import ttc_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);

  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADC_W-1:0]  smp;
  logic [STAT_W-1:0] st;
  logic              acc, last;

  assign smp       = in_tdata[ADC_W-1:0];
  assign in_tready = push_ready_i;
  assign acc       = in_tvalid & in_tready;
  assign last      = (cnt_r == CNT_W'(SAMPLES_PER_RESULT - 1));
  assign sum_add   = sum_r + SUM_W'(smp);

  always_comb begin
    if (smp == '0)           st = ST_SHORT;
    else if (smp == ADC_FULL) st = ST_OPEN;
    else                     st = ST_OK;
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      if (last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  assign push_valid_o = acc & last;
  assign push_data_o  = {sum_add, st};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/ttc_fifo.sv @@
// ----------------------------------------------------------------------------
// ttc_fifo
// Two-entry queue between the accumulator and the converter.
// ----------------------------------------------------------------------------
module ttc_fifo #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_r [2];
  logic         wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;

  assign push_ready_o = (cnt_r != 2'd2);
  assign pop_valid_o  = (cnt_r != 2'd0);
  assign pop_data_o   = mem_r[rd_r];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data_i;
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/ttc_back.sv @@
// ----------------------------------------------------------------------------
// ttc_back
// Converts one group sum into resistance and temperature, step by step.
// ----------------------------------------------------------------------------
`include "thermistor_temperature_converter_assert.svh"

module ttc_back #(
  parameter int SAMPLES_PER_RESULT = ttc_pkg::SAMPLES_PER_RESULT_DEF,
  parameter int SUM_W = $clog2(SAMPLES_PER_RESULT * 1023 + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [SUM_W+ttc_pkg::STAT_W-1:0] pop_data_i,
  input  logic [ttc_pkg::SERIES_W-1:0]  series_i,
  input  logic [ttc_pkg::COEF_W-1:0]    a0_i,
  input  logic [ttc_pkg::COEF_W-1:0]    a1_i,
  input  logic [ttc_pkg::COEF_W-1:0]    a3_i,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,
  output logic [1:0]                    out_tuser
);
  import ttc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_LG   = 4'd4;
  localparam logic [3:0] S_LN   = 4'd5;
  localparam logic [3:0] S_LN2  = 4'd6;
  localparam logic [3:0] S_LN3  = 4'd7;
  localparam logic [3:0] S_T1   = 4'd8;
  localparam logic [3:0] S_T3   = 4'd9;
  localparam logic [3:0] S_CHK  = 4'd10;
  localparam logic [3:0] S_REC  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [DIV_W-1:0] FULL_SCALE = DIV_W'(SAMPLES_PER_RESULT * 1024);

  logic [3:0]         st_r, st_nxt;
  logic [DIV_W-1:0]   norm_r, norm_nxt;
  logic [5:0]         p_r, p_nxt;
  logic [23:0]        frac_r, frac_nxt;
  logic [4:0]         it_r, it_nxt;
  logic [31:0]        m_r, m_nxt;
  logic               ln_neg_r, ln_neg_nxt;
  logic [MUL_W-1:0]   ln_mag_r, ln_mag_nxt, ln3_mag_r, ln3_mag_nxt;
  logic signed [63:0] d_r, d_nxt;
  logic [TEMP_W-1:0]  temp_r, temp_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic               ov_r, ov_nxt;
  logic [39:0]        od_r, od_nxt;
  logic [1:0]         ou_r, ou_nxt;

  logic               mul_start, div_start, load_out;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [DIV_W-1:0]   div_num, div_den;
  unit_sts_t          mul_sts, div_sts;
  logic [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]   quo;

  logic [SUM_W-1:0]   sum_in;
  logic [39:0]        rs;
  logic [32:0]        sq;
  logic signed [30:0] lg;
  logic [MUL_W-1:0]   lg_mag, a1_mag, a3_mag;
  logic signed [63:0] term, a0_s;
  logic [63:0]        term_mag;
  logic [40:0]        xq;
  logic signed [41:0] v, tq;

  assign sum_in = pop_data_i[SUM_W+STAT_W-1:STAT_W];
  assign rs     = series_i * SUM_W'(sum_in);
  assign sq     = prod[63:31];
  assign lg     = $signed({1'b0, p_r, frac_r}) - $signed(31'(16 << 24));
  assign lg_mag = lg[30] ? MUL_W'(-lg) : MUL_W'(lg);
  assign a1_mag = a1_i[COEF_W-1] ? -a1_i : a1_i;
  assign a3_mag = a3_i[COEF_W-1] ? -a3_i : a3_i;
  assign a0_s   = 64'($signed(a0_i));
  assign term_mag = prod[87:24];
  assign xq     = (quo > 64'(1) << 40) ? 41'(1) << 40 : quo[40:0];
  assign v      = $signed({1'b0, xq}) - $signed(OFFSET_K128);
  assign tq     = v >>> 1;

  always_comb begin
    st_nxt      = st_r;
    norm_nxt    = norm_r;
    p_nxt       = p_r;
    frac_nxt    = frac_r;
    it_nxt      = it_r;
    m_nxt       = m_r;
    ln_neg_nxt  = ln_neg_r;
    ln_mag_nxt  = ln_mag_r;
    ln3_mag_nxt = ln3_mag_r;
    d_nxt       = d_r;
    temp_nxt    = temp_r;
    res_nxt     = res_r;
    stat_nxt    = stat_r;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    term        = '0;

    unique case (st_r)
      S_IDLE: begin
        if (pop_valid_i) begin
          pop_ready_o = 1'b1;
          stat_nxt    = pop_data_i[STAT_W-1:0];
          div_start   = 1'b1;
          div_num     = {8'd0, rs, 16'd0};
          div_den     = FULL_SCALE - DIV_W'(sum_in);
          st_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (quo == '0) begin
            temp_nxt = 16'h8000;
            res_nxt  = '0;
            st_nxt   = S_OUT;
          end else begin
            res_nxt  = (quo[63:40] != '0) ? '1 : quo[39:16];
            norm_nxt = quo;
            p_nxt    = 6'd63;
            st_nxt   = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (norm_r[63]) begin
          m_nxt     = norm_r[63:32];
          frac_nxt  = '0;
          it_nxt    = '0;
          mul_start = 1'b1;
          mul_a     = MUL_W'(norm_r[63:32]);
          mul_b     = MUL_W'(norm_r[63:32]);
          st_nxt    = S_SQ;
        end else begin
          norm_nxt = norm_r << 1;
          p_nxt    = p_r - 1'b1;
        end
      end
      S_SQ: begin
        if (mul_sts.done) begin
          frac_nxt = {frac_r[22:0], sq[32]};
          m_nxt    = sq[32] ? sq[32:1] : sq[31:0];
          it_nxt   = it_r + 1'b1;
          if (it_r == 5'd23) begin
            st_nxt = S_LG;
          end else begin
            mul_start = 1'b1;
            mul_a     = MUL_W'(m_nxt);
            mul_b     = MUL_W'(m_nxt);
          end
        end
      end
      S_LG: begin
        ln_neg_nxt = lg[30];
        mul_start  = 1'b1;
        mul_a      = lg_mag;
        mul_b      = LN2_Q30;
        st_nxt     = S_LN;
      end
      S_LN: begin
        if (mul_sts.done) begin
          ln_mag_nxt = prod[MUL_W+29:30];
          mul_start  = 1'b1;
          mul_a      = ln_mag_nxt;
          mul_b      = ln_mag_nxt;
          st_nxt     = S_LN2;
        end
      end
      S_LN2: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          mul_a     = prod[MUL_W+23:24];
          mul_b     = ln_mag_r;
          st_nxt    = S_LN3;
        end
      end
      S_LN3: begin
        if (mul_sts.done) begin
          ln3_mag_nxt = prod[MUL_W+23:24];
          mul_start   = 1'b1;
          mul_a       = a1_mag;
          mul_b       = ln_mag_r;
          st_nxt      = S_T1;
        end
      end
      S_T1: begin
        if (mul_sts.done) begin
          term      = (a1_i[COEF_W-1] ^ ln_neg_r) ? -$signed(term_mag) : $signed(term_mag);
          d_nxt     = a0_s + term;
          mul_start = 1'b1;
          mul_a     = a3_mag;
          mul_b     = ln3_mag_r;
          st_nxt    = S_T3;
        end
      end
      S_T3: begin
        if (mul_sts.done) begin
          term   = (a3_i[COEF_W-1] ^ ln_neg_r) ? -$signed(term_mag) : $signed(term_mag);
          d_nxt  = d_r + term;
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (d_r <= 0) begin
          temp_nxt = 16'h7FFF;
          st_nxt   = S_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = 64'(1) << 63;
          div_den   = d_r;
          st_nxt    = S_REC;
        end
      end
      S_REC: begin
        if (div_sts.done) begin
          if (tq > 42'sd32767)       temp_nxt = 16'h7FFF;
          else if (tq < -42'sd32768) temp_nxt = 16'h8000;
          else                       temp_nxt = tq[15:0];
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          load_out = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt = ov_r & ~out_tready;
    od_nxt = od_r;
    ou_nxt = ou_r;
    if (load_out) begin
      ov_nxt = 1'b1;
      od_nxt = {res_r, temp_r};
      ou_nxt = stat_r;
    end
  end

  always_ff @(posedge clk) begin
    norm_r    <= norm_nxt;
    p_r       <= p_nxt;
    frac_r    <= frac_nxt;
    it_r      <= it_nxt;
    m_r       <= m_nxt;
    ln_neg_r  <= ln_neg_nxt;
    ln_mag_r  <= ln_mag_nxt;
    ln3_mag_r <= ln3_mag_nxt;
    d_r       <= d_nxt;
    temp_r    <= temp_nxt;
    res_r     <= res_nxt;
    stat_r    <= stat_nxt;
    od_r      <= od_nxt;
    ou_r      <= ou_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  ttc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (prod)
  );

  ttc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .quo_o   (quo)
  );

  `TTC_ASSERT_NOW(a_mul_idle_start, mul_start, !mul_sts.busy, "multiplier restarted while busy")
  `TTC_ASSERT_NOW(a_norm_nonzero, st_r == S_NORM, norm_r != '0, "normalising a zero quotient")
  `TTC_ASSERT_NOW(a_mul_done_wait, mul_sts.done, st_r == S_SQ || st_r == S_LN || st_r == S_LN2 || st_r == S_LN3 || st_r == S_T1 || st_r == S_T3, "product arrived outside a wait state")
  `TTC_ASSERT_NEXT(a_load_valid, load_out, out_tvalid, "loaded result not presented")

endmodule

@@ design/thermistor_temperature_converter.sv @@
// Conversion of a group after its last sample: divide, normalise, 24 log squarings,
//   5 multiplies and a reciprocal divide.
// Throughput: one sample per cycle while the two-group queue has room, else in_tready drops;
//   sustained about one group per conversion, set by the shared iterative multiplier and divider.
// Reset: synchronous active-low rst_n clears the group sum, count, queue and handshakes,
//   and loads the register defaults.
// ----------------------------------------------------------------------------
// thermistor_temperature_converter
// Sums groups of ADC samples and converts each group to ohms and 1/64 degC.
// ----------------------------------------------------------------------------
module thermistor_temperature_converter #(
  parameter int SAMPLES_PER_RESULT = ttc_pkg::SAMPLES_PER_RESULT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,    // [9:0] adc_sample
  // result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,   // [15:0] temperature, [39:16] resistance
  output logic [1:0]                    out_tuser,   // [1:0] status
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ttc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttc_pkg::COEF_W-1:0]    cfg_data
);
  import ttc_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES_PER_RESULT * 1023 + 1);
  localparam int QW    = SUM_W + STAT_W;

  // configuration registers; writes are to be made only while the block is idle, which the block does not enforce
  logic [SERIES_W-1:0] series_r, series_nxt;
  logic [COEF_W-1:0]   a0_r, a0_nxt, a1_r, a1_nxt, a3_r, a3_nxt;

  // front to back queue
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    series_nxt = series_r;
    a0_nxt     = a0_r;
    a1_nxt     = a1_r;
    a3_nxt     = a3_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SERIES: series_nxt = cfg_data[SERIES_W-1:0];
        REG_A0:     a0_nxt     = cfg_data;
        REG_A1:     a1_nxt     = cfg_data;
        REG_A3:     a3_nxt     = cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RST;
      a0_r     <= A0_RST;
      a1_r     <= A1_RST;
      a3_r     <= A3_RST;
    end else begin
      series_r <= series_nxt;
      a0_r     <= a0_nxt;
      a1_r     <= a1_nxt;
      a3_r     <= a3_nxt;
    end
  end

  // sample classification and group sum
  ttc_front #(
    .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
    .SUM_W              (SUM_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // two finished groups may wait here while the converter works
  ttc_fifo #(
    .W (QW)
  ) u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // resistance, log and reciprocal sequencer with output register
  ttc_back #(
    .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
    .SUM_W              (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .series_i    (series_r),
    .a0_i        (a0_r),
    .a1_i        (a1_r),
    .a3_i        (a3_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
